// ===== design/lfd_pkg.sv =====
// Shared types and constants for the length-framed deframer with sum check.
package lfd_pkg;

  // Reset value of the start byte register, ASCII 'b'
  localparam logic [7:0] START_BYTE_RESET = 8'd98;

  // Depth of the result queue; room for two results is needed per item
  localparam int RES_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CHECK   = 3'd3,
    PH_DRAIN   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    K_DATA     = 3'd0,
    K_GOOD     = 3'd1,
    K_BADSUM   = 3'd2,
    K_BADSTART = 3'd3,
    K_TRUNC    = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [7:0]  byte_index;
    logic [7:0]  frame_length;
    logic        last;
  } result_t;

  // Results produced by one item, handed to the queue together
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ===== design/length_frame_deframer_sum_check_unit.sv =====
// Top level of the length-framed deframer with 8-bit sum check.
//
// Bytes of a received buffer enter on the s_axis channel, one per item,
// with tlast on the final byte of the buffer. The first byte must match
// the start byte register, the second is the frame length N, the next N
// bytes are passed out as data results, and the byte after them is checked
// against the 8-bit wrapping sum of start byte, N and the N bytes.
// Results leave on m_axis: tuser carries the kind (data, good, bad sum,
// bad start, truncated), tdata the byte, its index and the frame length,
// and tlast marks the final result caused by one input byte.
// An accepted item is held in the input register and parsed once the
// result queue has room for two results; its results are written into
// the queue, which offers them on m_axis. One item per cycle is sustained
// while the queue has room; a byte ending a buffer mid-payload gives two
// results, through the input register, parse logic and four-entry queue.
// When the receiver stalls the queue fills and s_axis_tready drops once
// fewer than two entries are free. Reset empties the queue, returns the
// parser to waiting for a start byte and sets the start byte to 'b'.
// cfg_wen writes cfg_wdata into the start byte register; write only idle.
module length_frame_deframer_sum_check_unit
  import lfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_buffer
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] byte_index,
                                      // [23:16] frame_length
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast    // last
);

  logic [7:0] start_byte_reg;
  push_t      push;
  logic       room;
  result_t    out_res;

  // Start byte configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte_reg <= START_BYTE_RESET;
    end else if (cfg_wen) begin
      start_byte_reg <= cfg_wdata;
    end
  end

  lfd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .start_byte (start_byte_reg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_eob     (s_axis_tlast),
    .room       (room),
    .push       (push)
  );

  lfd_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // Result packing
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {out_res.frame_length, out_res.byte_index,
                         out_res.payload_byte};
  assign m_axis_tlast = out_res.last;

endmodule

// ===== design/lfd_parser.sv =====
// Input register, frame parser state and per-item result generation.
module lfd_parser
  import lfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] start_byte,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_eob,
  input  logic       room,
  output push_t      push
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_eob;
  logic       advance;

  phase_t     phase, phase_next;
  logic [7:0] length_seen, length_seen_next;
  logic [7:0] bytes_taken, bytes_taken_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] taken_inc;
  logic [7:0] sum_add;

  assign advance  = held_valid && room;
  assign in_ready = !held_valid || room;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
      held_eob  <= in_eob;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      length_seen <= '0;
      bytes_taken <= '0;
      running_sum <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      length_seen <= length_seen_next;
      bytes_taken <= bytes_taken_next;
      running_sum <= running_sum_next;
    end
  end

  assign taken_inc = bytes_taken + 8'd1;
  assign sum_add   = running_sum + held_byte;

  // Next state and results of the held item
  always_comb begin
    phase_next       = phase;
    length_seen_next = length_seen;
    bytes_taken_next = bytes_taken;
    running_sum_next = running_sum;
    push             = '0;
    push.r0.kind     = K_DATA;
    push.r1.kind     = K_DATA;

    case (phase)
      PH_START: begin
        if (held_byte != start_byte) begin
          push.count   = 2'd1;
          push.r0.kind = K_BADSTART;
          phase_next   = held_eob ? PH_START : PH_DRAIN;
        end else if (held_eob) begin
          push.count   = 2'd1;
          push.r0.kind = K_TRUNC;
          phase_next   = PH_START;
        end else begin
          running_sum_next = held_byte;
          length_seen_next = '0;
          bytes_taken_next = '0;
          phase_next       = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        length_seen_next = held_byte;
        running_sum_next = sum_add;
        bytes_taken_next = '0;
        if (held_eob) begin
          push.count           = 2'd1;
          push.r0.kind         = K_TRUNC;
          push.r0.frame_length = held_byte;
          phase_next           = PH_START;
        end else begin
          phase_next = (held_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        push.count           = 2'd1;
        push.r0.kind         = K_DATA;
        push.r0.payload_byte = held_byte;
        push.r0.byte_index   = bytes_taken;
        push.r0.frame_length = length_seen;
        running_sum_next     = sum_add;
        bytes_taken_next     = taken_inc;
        if (held_eob) begin
          // truncated inside the payload: data byte then status
          push.count           = 2'd2;
          push.r1.kind         = K_TRUNC;
          push.r1.frame_length = length_seen;
          phase_next           = PH_START;
        end else if (taken_inc == length_seen) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        push.count           = 2'd1;
        push.r0.kind         = (held_byte == running_sum) ? K_GOOD : K_BADSUM;
        push.r0.frame_length = length_seen;
        phase_next           = held_eob ? PH_START : PH_DRAIN;
      end
      default: begin
        // draining to end of buffer
        if (held_eob) begin
          phase_next = PH_START;
        end
      end
    endcase

    push.r0.last = (push.count == 2'd1);
    push.r1.last = (push.count == 2'd2);
    if (!advance) begin
      push.count = 2'd0;
    end
  end

  // Two results only come from a truncated payload byte
  a_two_only_payload: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (phase == PH_PAYLOAD && held_eob))
    else $error("two results outside a truncated payload byte");

  // Every buffer end returns the parser to the start phase
  a_eob_restarts: assert property (@(posedge clk) disable iff (rst)
    (advance && held_eob) |=> (phase == PH_START))
    else $error("parser did not restart after end of buffer");

  // Payload index stays below the frame length
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (bytes_taken < length_seen))
    else $error("payload index reached frame length");

endmodule

// ===== design/lfd_result_queue.sv =====
// Small result queue: takes up to two results per cycle, gives one while ready.
module lfd_result_queue
  import lfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  localparam int PTR_W = $clog2(RES_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  result_t            slots [RES_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_res   = slots[rd_ptr];
  assign room      = (count <= CNT_W'(RES_DEPTH - 2));

  // Storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      slots[PTR_W'(wr_ptr + 1'b1)] <= push.r1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PTR_W'(wr_ptr + PTR_W'(push.count));
      if (pop) begin
        rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      end
      count <= CNT_W'(count + CNT_W'(push.count) - CNT_W'(pop));
    end
  end

  // A push only arrives when two slots are free
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (count <= CNT_W'(RES_DEPTH - 2)))
    else $error("result queue overflow");

  // Fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(RES_DEPTH))
    else $error("result queue count out of range");

endmodule
